// ===== hdl/plob_pkg.sv =====
`default_nettype none
package plob_pkg;

  localparam int LEVELS = 64;
  localparam int PRICE_W = 32;
  localparam int QTY_W = 32;
  localparam int VOL_W = 39;
  localparam int DEPTH_W = 7;
  localparam int MAX_RESULTS = 64;
  localparam int CNT_W = $clog2(LEVELS + 1);
  localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int EXT_W = (CNT_W > DEPTH_W) ? CNT_W : DEPTH_W;

  typedef enum logic [2:0] {
    FN_CLEAR  = 3'd0,
    FN_INSERT = 3'd1,
    FN_DEPTH  = 3'd2,
    FN_VOLP   = 3'd3,
    FN_RANGE  = 3'd4,
    FN_TOTAL  = 3'd5,
    FN_RSV6   = 3'd6,
    FN_RSV7   = 3'd7
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SNAP,
    ST_SCAN,
    ST_FINAL
  } state_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_WRITE,
    OP_SHIFT,
    OP_ROTATE
  } cell_op_t;

  // Command broadcast to every cell of one side.
  typedef struct packed {
    cell_op_t            op;
    logic                is_bid;
    logic [PRICE_W-1:0]  key;
    logic [QTY_W-1:0]    new_qty;
  } side_ctrl_t;

  // Saturating volume accumulate.
  function automatic logic [VOL_W-1:0] sat_add(input logic [VOL_W-1:0] a,
                                               input logic [QTY_W-1:0] b);
    logic [VOL_W:0] s;
    s = {1'b0, a} + (VOL_W + 1)'(b);
    return s[VOL_W] ? {VOL_W{1'b1}} : s[VOL_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/price_level_order_book_core.sv =====
`default_nettype none
// Price-level order book. Each side is a row of LEVELS cells kept sorted
// (asks ascending, bids descending), so cell 0 is the top of book. Clear and
// insert act in the execute state, then pass the snapshot and final states:
// the sorted insert shifts every cell of the row together. Depth readout,
// volume at price, range volume and side total rotate both rows once around
// their ring, reading one level per side from cell 0 each cycle unless a level
// to emit waits on a stalled output. Volume answers and an empty depth readout
// give their result from the final state; a depth readout with levels to emit
// gives each as the scan reaches it and frees the input when the scan ends.
// One transaction is worked on at a time; the input is ready again only once
// the final result is in the output register.
module price_level_order_book_core (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // price[31:0], price_high[63:32], quantity[95:64], depth[102:96], zero pad
  input  wire logic [103:0] s_axis_tdata,
  // func[2:0], book_side[3]
  input  wire logic [3:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // best_ask_price[31:0], best_ask_qty[63:32], best_bid_price[95:64],
  // best_bid_qty[127:96], mid_twice[160:128], spread[193:161],
  // level_price[225:194], level_qty[257:226], volume[296:258], zero pad
  output logic [303:0]      m_axis_tdata,
  // status[0]
  output logic              m_axis_tuser,
  output logic              m_axis_tlast
);

  localparam int PW = plob_pkg::PRICE_W;
  localparam int QW = plob_pkg::QTY_W;
  localparam int VW = plob_pkg::VOL_W;
  localparam int CW = plob_pkg::CNT_W;
  localparam int KW = plob_pkg::LVL_W;
  localparam int XW = plob_pkg::EXT_W;

  plob_pkg::state_t st, st_next;
  plob_pkg::func_t  func_r;
  logic             side_r;
  logic [PW-1:0]    key_r;
  logic [PW-1:0]    hi_r;
  logic [QW-1:0]    qty_r;
  logic [plob_pkg::DEPTH_W-1:0] depth_r;
  logic [CW-1:0]    ask_count, ask_count_next;
  logic [CW-1:0]    bid_count, bid_count_next;
  logic [KW-1:0]    k;
  logic [CW-1:0]    nemit;
  logic [VW-1:0]    acc;
  logic             found_a, found_b;
  logic [QW-1:0]    fq_a, fq_b;
  logic [PW-1:0]    ap, bp;
  logic [QW-1:0]    aq, bq;
  logic [PW:0]      mid, spr;
  logic             status_r;

  logic             out_valid;
  logic [PW-1:0]    o_ap, o_bp;
  logic [QW-1:0]    o_aq, o_bq;
  logic [PW:0]      o_mid, o_spr;
  logic [PW-1:0]    o_lp;
  logic [QW-1:0]    o_lq;
  logic [VW-1:0]    o_vol;
  logic             o_last;
  logic             o_status;

  plob_pkg::side_ctrl_t ask_ctrl, bid_ctrl;
  logic [PW-1:0] a_hp, b_hp;
  logic [QW-1:0] a_hq, b_hq;
  logic          a_hit, b_hit;

  logic          out_free;
  logic          accept;
  logic          a_valid, b_valid;
  logic          emit_lvl;
  logic          emit_final;
  logic          proceed;
  logic          ins_full;
  logic [CW-1:0] sel_count;
  logic [plob_pkg::DEPTH_W-1:0] d_cap;
  logic [CW-1:0] n_calc;
  logic [VW-1:0] acc_next;
  logic [VW-1:0] final_vol;

  assign out_free      = !out_valid || m_axis_tready;
  assign s_axis_tready = (st == plob_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Level at cell 0 during the scan is entry k of each side.
  assign a_valid = ask_count > CW'(k);
  assign b_valid = bid_count > CW'(k);
  assign emit_lvl = (st == plob_pkg::ST_SCAN) && (func_r == plob_pkg::FN_DEPTH) &&
                    (CW'(k) < nemit);
  assign proceed  = !emit_lvl || out_free;
  assign emit_final = (st == plob_pkg::ST_FINAL) && out_free;

  assign sel_count = side_r ? bid_count : ask_count;
  assign ins_full  = (sel_count == CW'(plob_pkg::LEVELS));
  assign d_cap     = (depth_r > plob_pkg::DEPTH_W'(plob_pkg::MAX_RESULTS)) ?
                     plob_pkg::DEPTH_W'(plob_pkg::MAX_RESULTS) : depth_r;
  assign n_calc    = (XW'(d_cap) < XW'(sel_count)) ? CW'(d_cap) : sel_count;

  // Commands to both rows of cells.
  always_comb begin
    ask_ctrl.op      = plob_pkg::OP_HOLD;
    ask_ctrl.is_bid  = 1'b0;
    ask_ctrl.key     = key_r;
    ask_ctrl.new_qty = qty_r;
    bid_ctrl.op      = plob_pkg::OP_HOLD;
    bid_ctrl.is_bid  = 1'b1;
    bid_ctrl.key     = key_r;
    bid_ctrl.new_qty = qty_r;
    ask_count_next   = ask_count;
    bid_count_next   = bid_count;
    if (st == plob_pkg::ST_EXEC) begin
      if (func_r == plob_pkg::FN_CLEAR) begin
        ask_count_next = '0;
        bid_count_next = '0;
      end else if (func_r == plob_pkg::FN_INSERT && qty_r != '0) begin
        if (side_r) begin
          if (b_hit) begin
            bid_ctrl.op = plob_pkg::OP_WRITE;
          end else if (!ins_full) begin
            bid_ctrl.op    = plob_pkg::OP_SHIFT;
            bid_count_next = bid_count + 1'b1;
          end
        end else begin
          if (a_hit) begin
            ask_ctrl.op = plob_pkg::OP_WRITE;
          end else if (!ins_full) begin
            ask_ctrl.op    = plob_pkg::OP_SHIFT;
            ask_count_next = ask_count + 1'b1;
          end
        end
      end
    end else if (st == plob_pkg::ST_SCAN && proceed) begin
      ask_ctrl.op = plob_pkg::OP_ROTATE;
      bid_ctrl.op = plob_pkg::OP_ROTATE;
    end
  end

  plob_side u_ask (
    .clk        (clk),
    .ctrl       (ask_ctrl),
    .count      (ask_count),
    .head_price (a_hp),
    .head_qty   (a_hq),
    .hit        (a_hit)
  );

  plob_side u_bid (
    .clk        (clk),
    .ctrl       (bid_ctrl),
    .count      (bid_count),
    .head_price (b_hp),
    .head_qty   (b_hq),
    .hit        (b_hit)
  );

  // Volume accumulation for one scan step.
  always_comb begin
    acc_next = acc;
    case (func_r)
      plob_pkg::FN_RANGE: begin
        acc_next = plob_pkg::sat_add(
                     plob_pkg::sat_add(acc, (a_valid && a_hp >= key_r && a_hp <= hi_r) ?
                                            a_hq : '0),
                     (b_valid && b_hp >= key_r && b_hp <= hi_r) ? b_hq : '0);
      end
      plob_pkg::FN_TOTAL: begin
        if (side_r) begin
          acc_next = plob_pkg::sat_add(acc, b_valid ? b_hq : '0);
        end else begin
          acc_next = plob_pkg::sat_add(acc, a_valid ? a_hq : '0);
        end
      end
      default: begin
      end
    endcase
  end

  // Volume answer of the final result.
  always_comb begin
    case (func_r)
      plob_pkg::FN_VOLP: begin
        final_vol = found_a ? VW'(fq_a) : (found_b ? VW'(fq_b) : '0);
      end
      plob_pkg::FN_RANGE, plob_pkg::FN_TOTAL: begin
        final_vol = acc;
      end
      default: begin
        final_vol = '0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    st_next = st;
    case (st)
      plob_pkg::ST_IDLE: begin
        if (accept) begin
          st_next = plob_pkg::ST_EXEC;
        end
      end
      plob_pkg::ST_EXEC: begin
        st_next = plob_pkg::ST_SNAP;
      end
      plob_pkg::ST_SNAP: begin
        if (func_r == plob_pkg::FN_DEPTH || func_r == plob_pkg::FN_VOLP ||
            func_r == plob_pkg::FN_RANGE || func_r == plob_pkg::FN_TOTAL) begin
          st_next = plob_pkg::ST_SCAN;
        end else begin
          st_next = plob_pkg::ST_FINAL;
        end
      end
      plob_pkg::ST_SCAN: begin
        if (proceed && k == KW'(plob_pkg::LEVELS - 1)) begin
          if (func_r == plob_pkg::FN_DEPTH && nemit != '0) begin
            st_next = plob_pkg::ST_IDLE;
          end else begin
            st_next = plob_pkg::ST_FINAL;
          end
        end
      end
      plob_pkg::ST_FINAL: begin
        if (out_free) begin
          st_next = plob_pkg::ST_IDLE;
        end
      end
      default: begin
        st_next = plob_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= plob_pkg::ST_IDLE;
      ask_count <= '0;
      bid_count <= '0;
      out_valid <= 1'b0;
    end else begin
      st        <= st_next;
      ask_count <= ask_count_next;
      bid_count <= bid_count_next;
      if (emit_lvl && out_free || emit_final) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Transaction fields, scan state and top-of-book snapshot.
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r  <= plob_pkg::func_t'(s_axis_tuser[2:0]);
      side_r  <= s_axis_tuser[3];
      key_r   <= s_axis_tdata[31:0];
      hi_r    <= s_axis_tdata[63:32];
      qty_r   <= s_axis_tdata[95:64];
      depth_r <= s_axis_tdata[102:96];
    end
    if (st == plob_pkg::ST_EXEC) begin
      status_r <= (func_r == plob_pkg::FN_INSERT) && (qty_r != '0) &&
                  !(side_r ? b_hit : a_hit) && ins_full;
    end
    if (st == plob_pkg::ST_SNAP) begin
      ap      <= (ask_count != '0) ? a_hp : '0;
      aq      <= (ask_count != '0) ? a_hq : '0;
      bp      <= (bid_count != '0) ? b_hp : '0;
      bq      <= (bid_count != '0) ? b_hq : '0;
      mid     <= (ask_count != '0 && bid_count != '0) ?
                 ({1'b0, a_hp} + {1'b0, b_hp}) : '0;
      spr     <= (ask_count != '0 && bid_count != '0) ?
                 ({1'b0, a_hp} - {1'b0, b_hp}) : '0;
      k       <= '0;
      nemit   <= n_calc;
      acc     <= '0;
      found_a <= 1'b0;
      found_b <= 1'b0;
    end
    if (st == plob_pkg::ST_SCAN && proceed) begin
      k   <= k + 1'b1;
      acc <= acc_next;
      if (func_r == plob_pkg::FN_VOLP && a_valid && a_hp == key_r && !found_a) begin
        found_a <= 1'b1;
        fq_a    <= a_hq;
      end
      if (func_r == plob_pkg::FN_VOLP && b_valid && b_hp == key_r && !found_b) begin
        found_b <= 1'b1;
        fq_b    <= b_hq;
      end
    end
    // Output register; the top of book is copied so that a stalled result
    // keeps it while the next transaction takes its own snapshot.
    if (emit_lvl && out_free || emit_final) begin
      o_ap  <= ap;
      o_aq  <= aq;
      o_bp  <= bp;
      o_bq  <= bq;
      o_mid <= mid;
      o_spr <= spr;
    end
    if (emit_lvl && out_free) begin
      o_lp     <= a_valid && !side_r ? a_hp : b_hp;
      o_lq     <= a_valid && !side_r ? a_hq : b_hq;
      o_vol    <= '0;
      o_last   <= (CW'(k) == nemit - 1'b1);
      o_status <= 1'b0;
    end else if (emit_final) begin
      o_lp     <= '0;
      o_lq     <= '0;
      o_vol    <= final_vol;
      o_last   <= 1'b1;
      o_status <= status_r;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, o_vol, o_lq, o_lp, o_spr, o_mid, o_bq, o_bp, o_aq, o_ap};
  assign m_axis_tuser  = o_status;
  assign m_axis_tlast  = o_last;

endmodule
`default_nettype wire

// ===== hdl/plob_cell.sv =====
`default_nettype none
module plob_cell (
  input  wire logic                            clk,
  input  wire plob_pkg::side_ctrl_t            ctrl,
  input  wire logic                            slot_valid,
  input  wire logic                            left_before,
  input  wire logic [plob_pkg::PRICE_W-1:0]    left_price,
  input  wire logic [plob_pkg::QTY_W-1:0]      left_qty,
  input  wire logic [plob_pkg::PRICE_W-1:0]    right_price,
  input  wire logic [plob_pkg::QTY_W-1:0]      right_qty,
  output logic [plob_pkg::PRICE_W-1:0]         price,
  output logic [plob_pkg::QTY_W-1:0]           qty,
  output logic                                 ahead,
  output logic                                 match
);

  // A held level sorts ahead of the key when it is better priced.
  assign ahead = slot_valid && (ctrl.is_bid ? (price > ctrl.key) : (price < ctrl.key));
  assign match = slot_valid && (price == ctrl.key);

  // Level storage: overwrite, sorted shift-in, or ring rotation.
  always_ff @(posedge clk) begin
    case (ctrl.op)
      plob_pkg::OP_WRITE: begin
        if (match) begin
          qty <= ctrl.new_qty;
        end
      end
      plob_pkg::OP_SHIFT: begin
        if (!ahead) begin
          if (left_before) begin
            price <= ctrl.key;
            qty   <= ctrl.new_qty;
          end else begin
            price <= left_price;
            qty   <= left_qty;
          end
        end
      end
      plob_pkg::OP_ROTATE: begin
        price <= right_price;
        qty   <= right_qty;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/plob_side.sv =====
`default_nettype none
module plob_side (
  input  wire logic                           clk,
  input  wire plob_pkg::side_ctrl_t           ctrl,
  input  wire logic [plob_pkg::CNT_W-1:0]     count,
  output logic [plob_pkg::PRICE_W-1:0]        head_price,
  output logic [plob_pkg::QTY_W-1:0]          head_qty,
  output logic                                hit
);

  logic [plob_pkg::PRICE_W-1:0] prices [plob_pkg::LEVELS];
  logic [plob_pkg::QTY_W-1:0]   qtys   [plob_pkg::LEVELS];
  logic [plob_pkg::LEVELS-1:0]  befores;
  logic [plob_pkg::LEVELS-1:0]  hit_bits;

  // Row of cells; each sees its left neighbor for shifting and its right for rotation.
  for (genvar i = 0; i < plob_pkg::LEVELS; i++) begin : g_cell
    localparam int L = (i == 0) ? 0 : i - 1;
    localparam int R = (i == plob_pkg::LEVELS - 1) ? 0 : i + 1;
    logic slot_valid;
    logic left_before;
    assign slot_valid  = count > plob_pkg::CNT_W'(i);
    assign left_before = (i == 0) ? 1'b1 : befores[L];
    plob_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .slot_valid  (slot_valid),
      .left_before (left_before),
      .left_price  (prices[L]),
      .left_qty    (qtys[L]),
      .right_price (prices[R]),
      .right_qty   (qtys[R]),
      .price       (prices[i]),
      .qty         (qtys[i]),
      .ahead       (befores[i]),
      .match       (hit_bits[i])
    );
  end

  assign head_price = prices[0];
  assign head_qty   = qtys[0];
  assign hit        = |hit_bits;

endmodule
`default_nettype wire

// ===== hdl/plob_checker.sv =====
`default_nettype none
module plob_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [303:0] m_axis_tdata,
  input wire logic         m_axis_tuser,
  input wire logic         m_axis_tlast
);

  // A stalled result transaction keeps its data.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Only one transaction is in work at a time.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after acceptance");

  // A dropped insert is reported in a single, final result.
  a_drop_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("drop status on a non-final result");

  // Reset empties the output register.
  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind price_level_order_book_core plob_checker u_plob_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;

  // One order or query as it enters the book.
  typedef struct {
    plob_pkg::func_t fn;
    logic        bid;
    logic [31:0] px;
    logic [31:0] px_hi;
    logic [31:0] qty;
    logic [6:0]  dep;
  } book_cmd_t;

  // One book report as it leaves the block, highest bits first.
  typedef struct packed {
    logic [38:0] vol;
    logic [31:0] lvl_qty;
    logic [31:0] lvl_px;
    logic [32:0] sprd;
    logic [32:0] mid2;
    logic [31:0] bid_qty;
    logic [31:0] bid_px;
    logic [31:0] ask_qty;
    logic [31:0] ask_px;
    logic        lst;
    logic        dropped;
  } book_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic [3:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [303:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;

  price_level_order_book_core u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  book_cmd_t    pending_cmds[$];
  book_report_t expected_reports[$];
  book_cmd_t    cur_cmd;
  logic         cmd_taken = 1'b0;
  int           cmds_accepted = 0;
  int           mismatches = 0;
  int           cycle_count = 0;

  // Shadow copy of the book.
  logic [31:0] side_px[2][plob_pkg::LEVELS];
  logic [31:0] side_qty[2][plob_pkg::LEVELS];
  int          side_cnt[2] = '{0, 0};

  function automatic book_report_t book_report(logic [31:0] lp, logic [31:0] lq,
                                               logic [38:0] v, logic l, logic st);
    book_report_t r;
    r = '0;
    if (side_cnt[0] > 0) begin
      r.ask_px = side_px[0][0];
      r.ask_qty = side_qty[0][0];
    end
    if (side_cnt[1] > 0) begin
      r.bid_px = side_px[1][0];
      r.bid_qty = side_qty[1][0];
    end
    if (side_cnt[0] > 0 && side_cnt[1] > 0) begin
      r.mid2 = {1'b0, r.ask_px} + {1'b0, r.bid_px};
      r.sprd = {1'b0, r.ask_px} - {1'b0, r.bid_px};
    end
    r.lvl_px = lp;
    r.lvl_qty = lq;
    r.vol = v;
    r.lst = l;
    r.dropped = st;
    return r;
  endfunction

  // Saturating sum of one side over an inclusive price window.
  function automatic logic [38:0] window_volume(int s, logic [31:0] lo, logic [31:0] hi,
                                                logic [38:0] acc);
    logic [39:0] sum;
    for (int i = 0; i < side_cnt[s]; i++) begin
      if (side_px[s][i] >= lo && side_px[s][i] <= hi) begin
        sum = {1'b0, acc} + 40'(side_qty[s][i]);
        acc = sum[39] ? {39{1'b1}} : sum[38:0];
      end
    end
    return acc;
  endfunction

  // Apply one accepted command to the shadow book and queue its reports.
  task automatic apply_to_book(book_cmd_t c);
    int s, i, n;
    logic [38:0] v;
    logic st;
    logic hit;
    s = c.bid;
    v = '0;
    st = 1'b0;
    hit = 1'b0;
    case (c.fn)
      plob_pkg::FN_CLEAR: begin
        side_cnt[0] = 0;
        side_cnt[1] = 0;
      end
      plob_pkg::FN_INSERT: begin
        if (c.qty != 0) begin
          i = 0;
          while (i < side_cnt[s] && (s ? side_px[s][i] > c.px : side_px[s][i] < c.px))
            i++;
          if (i < side_cnt[s] && side_px[s][i] == c.px) begin
            side_qty[s][i] = c.qty;
          end else if (side_cnt[s] >= plob_pkg::LEVELS) begin
            st = 1'b1;
          end else begin
            for (int k = side_cnt[s]; k > i; k--) begin
              side_px[s][k] = side_px[s][k-1];
              side_qty[s][k] = side_qty[s][k-1];
            end
            side_px[s][i] = c.px;
            side_qty[s][i] = c.qty;
            side_cnt[s]++;
          end
        end
      end
      plob_pkg::FN_DEPTH: begin
        n = side_cnt[s];
        if (n > c.dep) n = c.dep;
        if (n > plob_pkg::MAX_RESULTS) n = plob_pkg::MAX_RESULTS;
        if (n == 0) begin
          expected_reports.push_back(book_report('0, '0, '0, 1'b1, 1'b0));
        end else begin
          for (int k = 0; k < n; k++)
            expected_reports.push_back(book_report(side_px[s][k], side_qty[s][k], '0,
                                                   k == n - 1, 1'b0));
        end
        return;
      end
      plob_pkg::FN_VOLP: begin
        for (int sd = 0; sd < 2; sd++)
          for (int k = 0; k < side_cnt[sd]; k++)
            if (!hit && side_px[sd][k] == c.px) begin
              v = side_qty[sd][k];
              hit = 1'b1;
            end
      end
      plob_pkg::FN_RANGE:
        v = window_volume(1, c.px, c.px_hi, window_volume(0, c.px, c.px_hi, '0));
      plob_pkg::FN_TOTAL: v = window_volume(s, '0, '1, '0);
      default: ;
    endcase
    expected_reports.push_back(book_report('0, '0, v, 1'b1, st));
  endtask

  task automatic add_cmd(plob_pkg::func_t fn, logic bid, logic [31:0] px,
                         logic [31:0] px_hi, logic [31:0] qty, logic [6:0] dep);
    book_cmd_t c;
    c.fn = fn;
    c.bid = bid;
    c.px = px;
    c.px_hi = px_hi;
    c.qty = qty;
    c.dep = dep;
    pending_cmds.push_back(c);
  endtask

  // Prices mostly near a common level so that overwrites and crossings happen.
  function automatic logic [31:0] pick_price();
    if ($urandom_range(0, 9) < 7) return 32'd1000 + $urandom_range(0, 40);
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_qty();
    if ($urandom_range(0, 9) == 0) return '0;
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $urandom_range(1, 500);
  endfunction

  // A random query against the current book.
  task automatic add_query();
    logic [31:0] lo;
    case ($urandom_range(0, 3))
      0: add_cmd(plob_pkg::FN_DEPTH, 1'($urandom_range(0, 1)), '0, '0, $urandom,
                 7'($urandom_range(0, 127)));
      1: add_cmd(plob_pkg::FN_VOLP, 1'($urandom_range(0, 1)), pick_price(), $urandom,
                 $urandom, 7'($urandom));
      2: begin
        lo = pick_price();
        add_cmd(plob_pkg::FN_RANGE, 1'($urandom_range(0, 1)), lo,
                ($urandom_range(0, 4) == 0) ? pick_price() : lo + $urandom_range(0, 30),
                $urandom, 7'($urandom));
      end
      default: add_cmd(plob_pkg::FN_TOTAL, 1'($urandom_range(0, 1)), $urandom, $urandom,
                       $urandom, 7'($urandom));
    endcase
  endtask

  // Stimulus: directed corner cases, one full side, then random sequences.
  initial begin
    int side;
    add_cmd(plob_pkg::FN_DEPTH, 1'b0, '0, '0, '0, 7'd5);
    add_cmd(plob_pkg::FN_CLEAR, 1'b1, '1, '1, '1, '1);
    add_cmd(plob_pkg::FN_INSERT, 1'b0, 32'd100, '0, '0, '0);
    add_cmd(plob_pkg::FN_INSERT, 1'b0, 32'd100, '0, 32'd5, '0);
    add_cmd(plob_pkg::FN_INSERT, 1'b0, 32'd0, '0, '1, '0);
    add_cmd(plob_pkg::FN_INSERT, 1'b1, '1, '0, 32'd1, '0);
    add_cmd(plob_pkg::FN_INSERT, 1'b0, 32'd100, '0, 32'd7, '0);
    add_cmd(plob_pkg::FN_INSERT, 1'b1, 32'd50, '0, 32'd3, '0);
    add_cmd(plob_pkg::FN_VOLP, 1'b0, 32'd100, '0, '0, '0);
    add_cmd(plob_pkg::FN_VOLP, 1'b1, 32'd50, '0, '0, '0);
    add_cmd(plob_pkg::FN_VOLP, 1'b0, 32'd77, '0, '0, '0);
    add_cmd(plob_pkg::FN_RANGE, 1'b0, '0, '1, '0, '0);
    add_cmd(plob_pkg::FN_RANGE, 1'b0, 32'd200, 32'd10, '0, '0);
    add_cmd(plob_pkg::FN_TOTAL, 1'b0, '0, '0, '0, '0);
    add_cmd(plob_pkg::FN_TOTAL, 1'b1, '0, '0, '0, '0);
    add_cmd(plob_pkg::FN_RSV6, 1'b0, '1, '1, '1, '1);
    add_cmd(plob_pkg::FN_RSV7, 1'b1, '0, '0, '0, '0);
    add_cmd(plob_pkg::FN_DEPTH, 1'b0, '0, '0, '0, 7'd64);
    add_cmd(plob_pkg::FN_DEPTH, 1'b1, '0, '0, '0, 7'd0);
    add_cmd(plob_pkg::FN_DEPTH, 1'b1, '0, '0, '0, 7'd127);
    add_cmd(plob_pkg::FN_CLEAR, 1'b0, '0, '0, '0, '0);
    add_cmd(plob_pkg::FN_DEPTH, 1'b0, '0, '0, '0, 7'd3);

    // Fill one side to capacity, then push past it.
    side = $urandom_range(0, 1);
    for (int i = 0; i < plob_pkg::LEVELS; i++)
      add_cmd(plob_pkg::FN_INSERT, 1'(side),
              {26'($urandom_range(0, 32'h3ff_ffff)), 6'(i)}, '0, pick_qty() | 1, '0);
    add_cmd(plob_pkg::FN_INSERT, 1'(side), 32'hffff_ffc1, '0, 32'd9, '0);
    add_cmd(plob_pkg::FN_INSERT, 1'(side), 32'd0, '0, '1, '0);
    add_cmd(plob_pkg::FN_DEPTH, 1'(side), '0, '0, '0, 7'd64);
    add_cmd(plob_pkg::FN_TOTAL, 1'(side), '0, '0, '0, '0);
    add_cmd(plob_pkg::FN_RANGE, 1'(side), '0, '1, '0, '0);

    while (pending_cmds.size() < 330) begin
      if ($urandom_range(0, 4) != 0) begin
        if ($urandom_range(0, 9) == 0)
          add_cmd(plob_pkg::FN_CLEAR, 1'($urandom), $urandom, $urandom, $urandom,
                  7'($urandom));
        repeat ($urandom_range(1, 8))
          add_cmd(plob_pkg::FN_INSERT, 1'($urandom_range(0, 1)), pick_price(), $urandom,
                  pick_qty(), 7'($urandom));
        repeat ($urandom_range(1, 3)) add_query();
      end else begin
        add_cmd(plob_pkg::func_t'($urandom_range(1, 7)), 1'($urandom), $urandom, $urandom,
                $urandom, 7'($urandom));
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    wait (pending_cmds.size() == 0 && !s_axis_tvalid && expected_reports.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0)
      $display("PASS price_level_order_book_core");
    else
      $display("FAIL price_level_order_book_core");
    $finish;
  end

  // Input side: bursts of commands separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (!rst && (!s_axis_tvalid || cmd_taken)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        cur_cmd = pending_cmds.pop_front();
        s_axis_tdata <= {1'b0, cur_cmd.dep, cur_cmd.qty, cur_cmd.px_hi, cur_cmd.px};
        s_axis_tuser <= {cur_cmd.bid, cur_cmd.fn};
        s_axis_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output side: stall pattern switches among random modes, with
  // one long hold-off while commands keep coming.
  int ready_mode = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  always @(negedge clk) begin
    if (!rst) begin
      if (cycle_count % 256 == 0) ready_mode <= $urandom_range(0, 3);
      if (!hold_done && cmds_accepted >= 120) begin
        hold_done <= 1'b1;
        hold_left <= 700;
        m_axis_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        case (ready_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 9) < 7);
          2: m_axis_tready <= (cycle_count % 5 == 0);
          default: m_axis_tready <= ($urandom_range(0, 19) == 0);
        endcase
      end
    end
  end

  // Accepted commands update the shadow book; accepted reports are checked.
  always @(posedge clk) begin
    book_report_t got, want;
    cycle_count <= cycle_count + 1;
    cmd_taken <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      cmds_accepted <= cmds_accepted + 1;
      apply_to_book(cur_cmd);
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[296:0], m_axis_tlast, m_axis_tuser};
      if (expected_reports.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("Unexpected transaction: %h", got);
      end else begin
        want = expected_reports.pop_front();
        if (got !== want) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("Mismatch: ask %h/%h bid %h/%h mid %h spr %h lvl %h/%h vol %h last %b st %b"
                     , got.ask_px, got.ask_qty, got.bid_px, got.bid_qty, got.mid2, got.sprd,
                     got.lvl_px, got.lvl_qty, got.vol, got.lst, got.dropped,
                     "\n  expected ask %h/%h bid %h/%h mid %h spr %h lvl %h/%h vol %h last %b st %b",
                     want.ask_px, want.ask_qty, want.bid_px, want.bid_qty, want.mid2,
                     want.sprd, want.lvl_px, want.lvl_qty, want.vol, want.lst, want.dropped);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    if (cycle_count >= 2000000) begin
      $display("FAIL price_level_order_book_core");
      $finish;
    end
  end

endmodule
